[hw/rtl/cnp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cnp_pkg;

    localparam logic [1:0] SHAPE_SPHERE  = 2'd0;
    localparam logic [1:0] SHAPE_CAPSULE = 2'd1;

    // configuration register indexes
    localparam logic REG_TINY_DISTANCE_SQ    = 1'b0;
    localparam logic REG_VERTICAL_TIE_MARGIN = 1'b1;

    localparam int unsigned QUO_W = 15;
    localparam int unsigned NUM_W = 46;

    localparam logic signed [15:0] NORMAL_ONE = 16'sd16384;

    typedef logic signed [15:0] norm_t;
    typedef norm_t [2:0] norm3_t;

    typedef struct packed {
        logic [1:0]         shape_a;
        logic [1:0]         shape_b;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic [29:0]        size_a_x;
        logic [29:0]        size_a_y;
        logic [29:0]        size_a_z;
        logic [29:0]        size_b_x;
        logic [29:0]        size_b_y;
        logic [29:0]        size_b_z;
    } cnp_in_t;

    typedef struct packed {
        logic        hit;
        norm_t       normal_x;
        norm_t       normal_y;
        norm_t       normal_z;
        logic [31:0] depth;
    } cnp_out_t;

    // carried alongside the root extraction
    typedef struct packed {
        logic             use_sqrt;
        logic             hit;
        norm3_t           dir_n;
        logic [31:0]      depth;
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic [30:0]      lim;
    } cnp_side_t;

    // carried alongside the normal division
    typedef struct packed {
        logic        hit;
        logic        use_div;
        logic [2:0]  neg;
        norm3_t      dir_n;
        logic [31:0] depth;
    } cnp_dside_t;

endpackage

`default_nettype wire

[hw/rtl/contact_narrow_phase_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                   Word
// input     s_valid / s_ready / s_data               one body pair (cnp_in_t)
// result    m_valid / m_ready / m_data               hit, normal, depth (cnp_out_t)
// config    cfg_valid / cfg_ready / cfg_index / cfg_data   register write
//
// One pair per cycle while no result is held; 5 front stages, 32 root stages
// (one root bit each), 1 numerator stage, 15 divider stages (one normal bit
// each, three lanes), 1 output register.
// Reset is synchronous and clears valid bits, not pipeline data; config
// registers return to their defaults. A held result stalls the whole pipe
// in step, so no word is lost or repeated; cfg_ready is always high.
module contact_narrow_phase_top #(
    parameter int FRACTION_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cnp_pkg::cnp_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cnp_pkg::cnp_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [31:0]       cfg_data
);
    import cnp_pkg::*;

    // 1e-4 in squared length units, rounded, saturated to 32 bits
    localparam longint unsigned TinyRaw =
        ((64'd1 << (2 * FRACTION_BITS)) + 64'd5000) / 64'd10000;
    localparam logic [31:0] TinyReset =
        (TinyRaw > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : TinyRaw[31:0];
    // half a length unit
    localparam logic [30:0] MarginReset = 31'(64'd1 << (FRACTION_BITS - 1));

    logic        en;
    logic        m_valid_reg;
    logic [31:0] tiny_reg;
    logic [30:0] margin_reg;

    // whole pipe advances unless the output word is held
    assign en        = !m_valid_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tiny_reg   <= TinyReset;
            margin_reg <= MarginReset;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TINY_DISTANCE_SQ:    tiny_reg   <= cfg_data;
                REG_VERTICAL_TIE_MARGIN: margin_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // front: decode, squares, squared distance, path choice
    logic        fr_valid;
    logic [63:0] fr_dsq;
    cnp_side_t   fr_side;

    cnp_front u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .en                  (en),
        .in_valid            (s_valid),
        .in_word             (s_data),
        .tiny_distance_sq    (tiny_reg),
        .vertical_tie_margin (margin_reg),
        .out_valid           (fr_valid),
        .out_dsq             (fr_dsq),
        .out_side            (fr_side)
    );

    // floor square root of the squared distance
    logic        sq_valid;
    logic [31:0] sq_root;
    cnp_side_t   sq_side;

    cnp_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_rad    (fr_dsq),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // numerator stage: penetration, rounded numerators |c|*16384 + dist/2
    logic                  post_valid_reg;
    logic [2:0][NUM_W-1:0] post_num_reg;
    logic [31:0]           post_den_reg;
    cnp_dside_t            post_side_reg;
    logic [2:0][NUM_W-1:0] post_num_next;
    cnp_dside_t            post_side_next;

    always_comb begin
        logic signed [32:0] pen;
        logic               pen_pos;
        pen     = $signed({2'b00, sq_side.lim}) - $signed({1'b0, sq_root});
        pen_pos = !pen[32] && (pen != 33'sd0);
        post_side_next.neg   = sq_side.neg;
        post_side_next.dir_n = sq_side.dir_n;
        if (sq_side.use_sqrt) begin
            post_side_next.hit     = pen_pos;
            post_side_next.use_div = pen_pos;
            post_side_next.depth   = pen[31:0];
        end else begin
            post_side_next.hit     = sq_side.hit;
            post_side_next.use_div = 1'b0;
            post_side_next.depth   = sq_side.depth;
        end
        for (int i = 0; i < 3; i++) begin
            post_num_next[i] = {sq_side.mag[i], 14'd0} + NUM_W'(sq_root >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            post_valid_reg <= 1'b0;
        end else if (en) begin
            post_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            post_num_reg  <= post_num_next;
            post_den_reg  <= sq_root;
            post_side_reg <= post_side_next;
        end
    end

    // normal components
    logic                  dv_valid;
    logic [2:0][QUO_W-1:0] dv_quo;
    cnp_dside_t            dv_side;

    cnp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (post_valid_reg),
        .in_num    (post_num_reg),
        .in_den    (post_den_reg),
        .in_side   (post_side_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    // output register: saturate and sign the quotients, blank misses
    cnp_out_t m_data_reg;
    cnp_out_t m_data_next;

    always_comb begin
        norm3_t      n;
        logic [14:0] qs;
        logic [15:0] nv;
        for (int i = 0; i < 3; i++) begin
            qs = (dv_quo[i] > 15'd16384) ? 15'd16384 : dv_quo[i];
            nv = {1'b0, qs};
            if (dv_side.use_div) begin
                n[i] = dv_side.neg[i] ? 16'(~nv + 16'd1) : nv;
            end else begin
                n[i] = dv_side.dir_n[i];
            end
        end
        m_data_next = '0;
        if (dv_side.hit) begin
            m_data_next.hit      = 1'b1;
            m_data_next.normal_x = n[0];
            m_data_next.normal_y = n[1];
            m_data_next.normal_z = n[2];
            m_data_next.depth    = dv_side.depth;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

[hw/rtl/cnp_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module cnp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  cnp_pkg::cnp_in_t    in_word,
    input  logic [31:0]         tiny_distance_sq,
    input  logic [30:0]         vertical_tie_margin,
    output logic                out_valid,
    output logic [63:0]         out_dsq,
    output cnp_pkg::cnp_side_t  out_side
);
    import cnp_pkg::*;

    typedef enum logic [1:0] {MODE_SS, MODE_SB, MODE_BB} mode_t;
    typedef logic [2:0][29:0] ext3_t;

    typedef struct packed {
        mode_t            mode;
        logic             dir_hit;
        norm3_t           dir_n;
        logic [31:0]      dir_depth;
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic [30:0]      lim;
        logic [63:0]      limsq;
    } carry_t;

    // faces +X -X -Y +Y -Z +Z: positive normal on bits 0, 3, 5
    localparam logic [5:0] FACE_POS = 6'b101001;

    function automatic ext3_t half_ext(input logic [1:0] shape, input logic [29:0] sx,
                                       input logic [29:0] sy, input logic [29:0] sz);
        ext3_t e;
        if (shape == SHAPE_CAPSULE) begin
            e[0] = sx;
            e[1] = sx;
            e[2] = (sz > sx) ? sz : sx;
        end else begin
            e[0] = sx;
            e[1] = sy;
            e[2] = sz;
        end
        return e;
    endfunction

    // ---- stage A: decode, clamp, faces, overlaps
    logic               a_valid_reg;
    mode_t              a_mode_reg;
    logic               a_swap_reg;
    logic [2:0][31:0]   a_mag_reg;
    logic [2:0]         a_vneg_reg;
    logic [30:0]        a_lim_reg;
    logic [29:0]        a_r_reg;
    logic signed [33:0] a_face_reg [6];
    logic signed [33:0] a_ov_reg [3];
    logic [2:0]         a_offneg_reg;
    logic               a_zdom_reg;

    mode_t              a_mode_next;
    logic               a_swap_next;
    logic [2:0][31:0]   a_mag_next;
    logic [2:0]         a_vneg_next;
    logic [30:0]        a_lim_next;
    logic [29:0]        a_r_next;
    logic signed [33:0] a_face_next [6];
    logic signed [33:0] a_ov_next [3];
    logic [2:0]         a_offneg_next;
    logic               a_zdom_next;

    always_comb begin
        logic signed [31:0] off_v [3];
        logic signed [33:0] p [3];
        logic signed [33:0] d [3];
        logic signed [33:0] es [3];
        logic signed [33:0] vec;
        logic [31:0]        ad [3];
        ext3_t              ea;
        ext3_t              eb;
        ext3_t              ebox;
        logic               sph_a;
        logic               sph_b;
        off_v[0] = in_word.offset_x;
        off_v[1] = in_word.offset_y;
        off_v[2] = in_word.offset_z;
        ea = half_ext(in_word.shape_a, in_word.size_a_x, in_word.size_a_y, in_word.size_a_z);
        eb = half_ext(in_word.shape_b, in_word.size_b_x, in_word.size_b_y, in_word.size_b_z);
        sph_a = (in_word.shape_a == SHAPE_SPHERE);
        sph_b = (in_word.shape_b == SHAPE_SPHERE);
        if (sph_a && sph_b) begin
            a_mode_next = MODE_SS;
        end else if (sph_a || sph_b) begin
            a_mode_next = MODE_SB;
        end else begin
            a_mode_next = MODE_BB;
        end
        ebox        = sph_a ? eb : ea;
        a_r_next    = sph_a ? in_word.size_a_x : in_word.size_b_x;
        a_swap_next = (a_mode_next == MODE_SB) && !sph_a;
        for (int i = 0; i < 3; i++) begin
            p[i]  = sph_a ? -34'(off_v[i]) : 34'(off_v[i]);
            es[i] = 34'(ebox[i]);
            if (p[i] < -es[i]) begin
                d[i] = -es[i] - p[i];
            end else if (p[i] > es[i]) begin
                d[i] = es[i] - p[i];
            end else begin
                d[i] = '0;
            end
            ad[i] = off_v[i][31] ? (32'(~off_v[i]) + 32'd1) : 32'(off_v[i]);
            a_ov_next[i]     = 34'(ea[i]) + 34'(eb[i]) - 34'(ad[i]);
            a_offneg_next[i] = off_v[i][31];
            vec = (a_mode_next == MODE_SS) ? 34'(off_v[i]) : d[i];
            a_vneg_next[i] = vec[33];
            a_mag_next[i]  = vec[33] ? 32'(-vec) : 32'(vec);
        end
        a_face_next[0] = es[0] - p[0];
        a_face_next[1] = p[0] + es[0];
        a_face_next[2] = p[1] + es[1];
        a_face_next[3] = es[1] - p[1];
        a_face_next[4] = p[2] + es[2];
        a_face_next[5] = es[2] - p[2];
        a_zdom_next = (ad[2] >= ad[0]) && (ad[2] >= ad[1]);
        a_lim_next  = (a_mode_next == MODE_SS) ?
                      (31'(in_word.size_a_x) + 31'(in_word.size_b_x)) : 31'(a_r_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_mode_reg   <= a_mode_next;
            a_swap_reg   <= a_swap_next;
            a_mag_reg    <= a_mag_next;
            a_vneg_reg   <= a_vneg_next;
            a_lim_reg    <= a_lim_next;
            a_r_reg      <= a_r_next;
            a_face_reg   <= a_face_next;
            a_ov_reg     <= a_ov_next;
            a_offneg_reg <= a_offneg_next;
            a_zdom_reg   <= a_zdom_next;
        end
    end

    // ---- stage B: squares, nearest face, box-box axis
    logic             b_valid_reg;
    carry_t           b_carry_reg;
    logic [2:0][63:0] b_sq_reg;
    carry_t           b_carry_next;
    logic [2:0][63:0] b_sq_next;

    always_comb begin
        logic signed [33:0] m;
        logic signed [33:0] fm;
        logic signed [35:0] fpen;
        logic signed [33:0] mn;
        logic signed [35:0] tie_lim;
        logic [2:0]         best;
        logic [1:0]         fax;
        logic [1:0]         bax;
        logic               fpos;
        norm3_t             fn;
        norm3_t             bn;
        logic               bhit;
        logic               fhit;
        logic [31:0]        fdepth;
        m    = a_face_reg[0];
        best = 3'd0;
        for (int i = 1; i < 6; i++) begin
            if (a_face_reg[i] < m) begin
                m    = a_face_reg[i];
                best = 3'(i);
            end
        end
        fax  = best[2:1];
        fpos = FACE_POS[best] ^ a_swap_reg;
        fn   = '0;
        fn[fax] = fpos ? NORMAL_ONE : -NORMAL_ONE;
        fm   = (m > 34'sd0) ? m : 34'sd0;
        fpen = 36'(a_r_reg) + 36'(fm);
        fhit = (fpen > 36'sd0);
        fdepth = (fpen[35:32] != 4'd0) ? 32'hFFFF_FFFF : fpen[31:0];

        mn = a_ov_reg[0];
        if (a_ov_reg[1] < mn) mn = a_ov_reg[1];
        if (a_ov_reg[2] < mn) mn = a_ov_reg[2];
        tie_lim = 36'(mn) + 36'(vertical_tie_margin);
        bhit = (a_ov_reg[0] > 34'sd0) && (a_ov_reg[1] > 34'sd0) && (a_ov_reg[2] > 34'sd0);
        if (a_zdom_reg || (36'(a_ov_reg[2]) <= tie_lim)) begin
            bax = 2'd2;
        end else if (a_ov_reg[0] <= a_ov_reg[1]) begin
            bax = 2'd0;
        end else begin
            bax = 2'd1;
        end
        bn = '0;
        bn[bax] = a_offneg_reg[bax] ? -NORMAL_ONE : NORMAL_ONE;

        b_carry_next.mode = a_mode_reg;
        if (a_mode_reg == MODE_BB) begin
            b_carry_next.dir_hit   = bhit;
            b_carry_next.dir_n     = bn;
            b_carry_next.dir_depth = 32'(a_ov_reg[bax]);
        end else begin
            b_carry_next.dir_hit   = fhit;
            b_carry_next.dir_n     = fn;
            b_carry_next.dir_depth = fdepth;
        end
        b_carry_next.mag   = a_mag_reg;
        b_carry_next.neg   = a_vneg_reg ^ {3{a_swap_reg}};
        b_carry_next.lim   = a_lim_reg;
        b_carry_next.limsq = 64'(a_lim_reg) * 64'(a_lim_reg);
        for (int i = 0; i < 3; i++) begin
            b_sq_next[i] = 64'(a_mag_reg[i]) * 64'(a_mag_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_carry_reg <= b_carry_next;
            b_sq_reg    <= b_sq_next;
        end
    end

    // ---- stages C and D: squared distance
    logic        c_valid_reg;
    carry_t      c_carry_reg;
    logic [63:0] c_s01_reg;
    logic [63:0] c_sq2_reg;
    logic        d_valid_reg;
    carry_t      d_carry_reg;
    logic [63:0] d_dsq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_carry_reg <= b_carry_reg;
            c_s01_reg   <= b_sq_reg[0] + b_sq_reg[1];
            c_sq2_reg   <= b_sq_reg[2];
            d_carry_reg <= c_carry_reg;
            d_dsq_reg   <= c_s01_reg + c_sq2_reg;
        end
    end

    // ---- stage E: path decision
    logic      e_valid_reg;
    logic [63:0] e_dsq_reg;
    cnp_side_t e_side_reg;
    cnp_side_t e_side_next;

    always_comb begin
        logic above_tiny;
        above_tiny = d_dsq_reg > 64'(tiny_distance_sq);
        e_side_next.dir_n = d_carry_reg.dir_n;
        e_side_next.depth = d_carry_reg.dir_depth;
        e_side_next.mag   = d_carry_reg.mag;
        e_side_next.neg   = d_carry_reg.neg;
        e_side_next.lim   = d_carry_reg.lim;
        case (d_carry_reg.mode)
            MODE_SS: begin
                e_side_next.use_sqrt = above_tiny && (d_dsq_reg < d_carry_reg.limsq);
                e_side_next.hit      = 1'b0;
            end
            MODE_SB: begin
                if (d_dsq_reg > d_carry_reg.limsq) begin
                    e_side_next.use_sqrt = 1'b0;
                    e_side_next.hit      = 1'b0;
                end else begin
                    e_side_next.use_sqrt = above_tiny;
                    e_side_next.hit      = !above_tiny && d_carry_reg.dir_hit;
                end
            end
            default: begin
                e_side_next.use_sqrt = 1'b0;
                e_side_next.hit      = d_carry_reg.dir_hit;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_dsq_reg  <= d_dsq_reg;
            e_side_reg <= e_side_next;
        end
    end

    assign out_valid = e_valid_reg;
    assign out_dsq   = e_dsq_reg;
    assign out_side  = e_side_reg;

endmodule

`default_nettype wire

[hw/rtl/cnp_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none

module cnp_sqrt (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [63:0]        in_rad,
    input  cnp_pkg::cnp_side_t in_side,
    output logic               out_valid,
    output logic [31:0]        out_root,
    output cnp_pkg::cnp_side_t out_side
);
    import cnp_pkg::*;

    localparam int STAGES = 32;

    logic        v_reg    [STAGES];
    logic [33:0] rem_reg  [STAGES];
    logic [31:0] root_reg [STAGES];
    logic [63:0] rad_reg  [STAGES];
    cnp_side_t   side_reg [STAGES];

    // one root bit per stage, two radicand bits consumed
    for (genvar k = 0; k < STAGES; k++) begin : g_stg
        logic        v_in;
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] rad_in;
        cnp_side_t   side_in;
        logic [33:0] rem_next;
        logic [31:0] root_next;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = in_rad;
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = v_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb begin
            logic [35:0] acc;
            logic [35:0] trial;
            acc   = {rem_in, rad_in[63-2*k -: 2]};
            trial = {2'b00, root_in, 2'b01};
            if (acc >= trial) begin
                rem_next  = 34'(acc - trial);
                root_next = {root_in[30:0], 1'b1};
            end else begin
                rem_next  = 34'(acc);
                root_next = {root_in[30:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= rad_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_root  = root_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

`default_nettype wire

[hw/rtl/cnp_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module cnp_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [2:0][cnp_pkg::NUM_W-1:0]  in_num,
    input  logic [31:0]                     in_den,
    input  cnp_pkg::cnp_dside_t             in_side,
    output logic                            out_valid,
    output logic [2:0][cnp_pkg::QUO_W-1:0]  out_quo,
    output cnp_pkg::cnp_dside_t             out_side
);
    import cnp_pkg::*;

    localparam int STAGES = QUO_W;
    localparam int REM_W  = NUM_W + 1;

    logic                  v_reg    [STAGES];
    logic [2:0][REM_W-1:0] rem_reg  [STAGES];
    logic [2:0][QUO_W-1:0] quo_reg  [STAGES];
    logic [31:0]           den_reg  [STAGES];
    cnp_dside_t            side_reg [STAGES];

    // restoring division, three lanes, one quotient bit per stage
    for (genvar j = 0; j < STAGES; j++) begin : g_stg
        localparam int B = QUO_W - 1 - j;
        logic                  v_in;
        logic [2:0][REM_W-1:0] rem_in;
        logic [2:0][QUO_W-1:0] quo_in;
        logic [31:0]           den_in;
        cnp_dside_t            side_in;
        logic [2:0][REM_W-1:0] rem_next;
        logic [2:0][QUO_W-1:0] quo_next;

        if (j == 0) begin : g_first
            assign v_in = in_valid;
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign rem_in[l] = REM_W'(in_num[l]);
            end
            assign quo_in  = '0;
            assign den_in  = in_den;
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = v_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign quo_in  = quo_reg[j-1];
            assign den_in  = den_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        always_comb begin
            logic [REM_W-1:0] dsh;
            dsh = REM_W'(den_in) << B;
            for (int l = 0; l < 3; l++) begin
                quo_next[l] = quo_in[l];
                if (rem_in[l] >= dsh) begin
                    rem_next[l]    = rem_in[l] - dsh;
                    quo_next[l][B] = 1'b1;
                end else begin
                    rem_next[l] = rem_in[l];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= rem_next;
                quo_reg[j]  <= quo_next;
                den_reg[j]  <= den_in;
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_quo   = quo_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

// Testbench for contact_narrow_phase_top.
// The pair generator below fills a pending queue. A clocked driver sends those
// pairs in bursts and drives at the falling edge. A clocked monitor samples at
// the rising edge. The contact predictor works out each expected word as the
// pair is accepted and queues it. The monitor checks every result word against
// the oldest queued expectation.
module testbench;
    import cnp_pkg::*;

    localparam int     LATENCY     = 54;
    localparam longint LIMIT       = 400000;
    localparam logic [1:0] SHAPE_BOX = 2'd2;
    localparam logic [1:0] SHAPE_ODD = 2'd3;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    cnp_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    cnp_out_t m_data;
    logic     cfg_valid = 1'b0;
    logic     cfg_ready;
    logic     cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;

    contact_narrow_phase_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // shadow copies of the block's registers
    logic [31:0] tiny_dsq;
    logic [30:0] tie_margin;

    cnp_in_t  pending_pairs[$];
    cnp_out_t expected_contacts[$];
    int  errors = 0;
    int  pairs_sent = 0;
    int  words_checked = 0;
    int  hits_seen = 0;
    longint cycles = 0;
    bit  hold_sender = 1'b0;
    bit  word_taken = 1'b0;

    // ---------------- contact predictor ----------------
    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned mag64(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    // component / distance in Q1.14, nearest with ties away from zero
    function automatic longint unit_part(longint c, longint unsigned root_d);
        longint unsigned q;
        q = (mag64(c) * 16384 + root_d / 2) / root_d;
        if (q > 16384) q = 16384;
        return c < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [31:0] clamp_depth(longint d);
        if (d <= 0) return '0;
        if (d > longint'(64'hFFFF_FFFF)) return 32'hFFFF_FFFF;
        return d[31:0];
    endfunction

    function automatic void extents(logic [1:0] shp, longint unsigned sz[3],
                                    output longint e[3]);
        if (shp == SHAPE_CAPSULE) begin
            e[0] = sz[0];
            e[1] = sz[0];
            e[2] = sz[2] > sz[0] ? sz[2] : sz[0];
        end else begin
            for (int i = 0; i < 3; i++) e[i] = sz[i];
        end
    endfunction

    // p: sphere centre relative to box centre; n points from sphere to box
    function automatic bit sphere_vs_box(longint p[3], longint unsigned r, longint e[3],
                                         output longint n[3],
                                         output logic [31:0] dep);
        longint d[3];
        longint unsigned dsq;
        longint unsigned root_d;
        longint face[6];
        int  axis_of[6] = '{0, 0, 1, 1, 2, 2};
        longint sgn_of[6] = '{1, -1, -1, 1, -1, 1};
        int  best;
        longint m, pen;
        longint c;
        dsq = 0;
        n = '{0, 0, 0};
        dep = '0;
        for (int i = 0; i < 3; i++) begin
            c = p[i];
            if (c < -e[i]) c = -e[i];
            if (c > e[i]) c = e[i];
            d[i] = c - p[i];
            dsq += mag64(d[i]) * mag64(d[i]);
        end
        if (dsq > r * r) return 1'b0;
        if (dsq > tiny_dsq) begin
            root_d = root_floor(dsq);
            pen = longint'(r) - longint'(root_d);
            if (pen <= 0) return 1'b0;
            for (int i = 0; i < 3; i++) n[i] = unit_part(d[i], root_d);
            dep = clamp_depth(pen);
            return 1'b1;
        end
        // centre inside the box or within the tiny distance: push out through the nearest face
        face[0] = e[0] - p[0];
        face[1] = p[0] + e[0];
        face[2] = p[1] + e[1];
        face[3] = e[1] - p[1];
        face[4] = p[2] + e[2];
        face[5] = e[2] - p[2];
        best = 0;
        m = face[0];
        for (int i = 1; i < 6; i++) begin
            if (face[i] < m) begin
                m = face[i];
                best = i;
            end
        end
        n[axis_of[best]] = sgn_of[best] * 16384;
        pen = longint'(r) + (m > 0 ? m : 0);
        if (pen <= 0) return 1'b0;
        dep = clamp_depth(pen);
        return 1'b1;
    endfunction

    function automatic cnp_out_t predict_contact(cnp_in_t pr);
        cnp_out_t o;
        longint off[3];
        longint unsigned sa[3], sb[3];
        longint n[3];
        logic [31:0] dep;
        bit  hit;
        longint unsigned dsq, mind, root_d;
        longint p[3], e[3], ea[3], eb[3], ov[3];
        longint unsigned ad[3];
        longint mn;
        int  ax;
        bit  a_sph, b_sph;
        off = '{longint'(pr.offset_x), longint'(pr.offset_y), longint'(pr.offset_z)};
        sa = '{pr.size_a_x, pr.size_a_y, pr.size_a_z};
        sb = '{pr.size_b_x, pr.size_b_y, pr.size_b_z};
        n = '{0, 0, 0};
        dep = '0;
        hit = 1'b0;
        a_sph = pr.shape_a == SHAPE_SPHERE;
        b_sph = pr.shape_b == SHAPE_SPHERE;
        if (a_sph && b_sph) begin
            dsq = 0;
            mind = sa[0] + sb[0];
            for (int i = 0; i < 3; i++) dsq += mag64(off[i]) * mag64(off[i]);
            if (dsq > tiny_dsq && dsq < mind * mind) begin
                root_d = root_floor(dsq);
                for (int i = 0; i < 3; i++) n[i] = unit_part(off[i], root_d);
                dep = clamp_depth(longint'(mind) - longint'(root_d));
                hit = 1'b1;
            end
        end else if (a_sph || b_sph) begin
            if (a_sph) extents(pr.shape_b, sb, e);
            else extents(pr.shape_a, sa, e);
            for (int i = 0; i < 3; i++) p[i] = a_sph ? -off[i] : off[i];
            hit = sphere_vs_box(p, a_sph ? sa[0] : sb[0], e, n, dep);
            if (hit && !a_sph) for (int i = 0; i < 3; i++) n[i] = -n[i];
        end else begin
            extents(pr.shape_a, sa, ea);
            extents(pr.shape_b, sb, eb);
            for (int i = 0; i < 3; i++) begin
                ad[i] = mag64(off[i]);
                ov[i] = ea[i] + eb[i] - longint'(ad[i]);
            end
            if (ov[0] > 0 && ov[1] > 0 && ov[2] > 0) begin
                mn = ov[0];
                if (ov[1] < mn) mn = ov[1];
                if (ov[2] < mn) mn = ov[2];
                if ((ad[2] >= ad[0] && ad[2] >= ad[1]) ||
                    ov[2] <= mn + longint'(tie_margin)) ax = 2;
                else if (ov[0] <= ov[1]) ax = 0;
                else ax = 1;
                n[ax] = off[ax] >= 0 ? 16384 : -16384;
                dep = clamp_depth(ov[ax]);
                hit = 1'b1;
            end
        end
        if (!hit) begin
            n = '{0, 0, 0};
            dep = '0;
        end
        o.hit = hit;
        o.normal_x = n[0][15:0];
        o.normal_y = n[1][15:0];
        o.normal_z = n[2][15:0];
        o.depth = dep;
        return o;
    endfunction

    // ---------------- pair generation ----------------
    function automatic logic [29:0] rand_size();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 30'h3FFF_FFFF;
            2: return 30'($urandom());
            default: return 30'($urandom_range(0, 40 << 16));
        endcase
    endfunction

    function automatic logic [31:0] rand_offset();
        case ($urandom_range(0, 11))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3: return $urandom();
            4: return $urandom_range(0, 3) - 1;
            default: return $signed($urandom_range(0, 120 << 16)) - (60 << 16);
        endcase
    endfunction

    function automatic cnp_in_t rand_pair();
        cnp_in_t pr;
        pr.shape_a = ($urandom_range(0, 19) == 0) ? SHAPE_ODD : 2'($urandom_range(0, 2));
        pr.shape_b = ($urandom_range(0, 19) == 0) ? SHAPE_ODD : 2'($urandom_range(0, 2));
        pr.offset_x = rand_offset();
        pr.offset_y = rand_offset();
        pr.offset_z = rand_offset();
        pr.size_a_x = rand_size();
        pr.size_a_y = rand_size();
        pr.size_a_z = rand_size();
        pr.size_b_x = rand_size();
        pr.size_b_y = rand_size();
        pr.size_b_z = rand_size();
        return pr;
    endfunction

    function automatic cnp_in_t make_pair(logic [1:0] a, logic [1:0] b,
                                          longint ox, longint oy, longint oz,
                                          longint ra, longint ha, longint rb, longint hb);
        cnp_in_t pr;
        pr.shape_a = a;
        pr.shape_b = b;
        pr.offset_x = ox[31:0];
        pr.offset_y = oy[31:0];
        pr.offset_z = oz[31:0];
        pr.size_a_x = ra[29:0];
        pr.size_a_y = ra[29:0];
        pr.size_a_z = ha[29:0];
        pr.size_b_x = rb[29:0];
        pr.size_b_y = rb[29:0];
        pr.size_b_z = hb[29:0];
        return pr;
    endfunction

    // ---------------- driver: bursts with random gaps ----------------
    int burst_left = 0;
    int gap_left = 0;

    // word_taken is set at the rising edge that accepted the word on the bus
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && !word_taken) begin
                // hold the word until it is taken
            end else if (!hold_sender && pending_pairs.size() != 0 && gap_left == 0) begin
                s_valid <= 1'b1;
                s_data <= pending_pairs[0];
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                end
                burst_left--;
                if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0 :
                                                $urandom_range(1, 12);
            end else begin
                s_valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end
            word_taken = 1'b0;
        end
    end

    // receiver stall pattern: long open stretches, then choppy phases
    always @(negedge aclk) begin
        case ((cycles >> 9) % 4)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ((cycles % 7) < 2);
            default: m_ready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    // acceptance of a pair: predict and queue the result word
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && s_valid && s_ready) begin
            expected_contacts.push_back(predict_contact(s_data));
            void'(pending_pairs.pop_front());
            pairs_sent++;
            word_taken = 1'b1;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge aclk) begin
        cnp_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_contacts.size() == 0) begin
                $display("%0t: result word with nothing expected: %h", $time, m_data);
                errors++;
            end else begin
                want = expected_contacts.pop_front();
                words_checked++;
                if (want.hit) hits_seen++;
                if (m_data.hit !== want.hit) begin
                    $display("%0t: hit expected %0d actual %0d", $time, want.hit, m_data.hit);
                    errors++;
                end
                if (m_data.normal_x !== want.normal_x) begin
                    $display("%0t: normal_x expected %0d actual %0d", $time,
                             want.normal_x, m_data.normal_x);
                    errors++;
                end
                if (m_data.normal_y !== want.normal_y) begin
                    $display("%0t: normal_y expected %0d actual %0d", $time,
                             want.normal_y, m_data.normal_y);
                    errors++;
                end
                if (m_data.normal_z !== want.normal_z) begin
                    $display("%0t: normal_z expected %0d actual %0d", $time,
                             want.normal_z, m_data.normal_z);
                    errors++;
                end
                if (m_data.depth !== want.depth) begin
                    $display("%0t: depth expected %0d actual %0d", $time,
                             want.depth, m_data.depth);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------- sequencing ----------------
    task automatic write_reg(bit idx, logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == REG_TINY_DISTANCE_SQ) tiny_dsq = val;
        else tie_margin = val[30:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_pairs.size() != 0 || s_valid || expected_contacts.size() != 0)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) pending_pairs.push_back(rand_pair());
    endtask

    localparam longint ONE = 1 << 16;

    initial begin
        tiny_dsq = 32'd429497;
        tie_margin = 31'd32768;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed pairs at reset settings
        pending_pairs.push_back(make_pair(SHAPE_SPHERE, SHAPE_SPHERE, 3 * ONE, 0, 0,
                                          2 * ONE, 0, 2 * ONE, 0));
        pending_pairs.push_back(make_pair(SHAPE_SPHERE, SHAPE_SPHERE, -ONE, ONE, -ONE,
                                          ONE, 0, ONE, 0));
        // sphere-sphere centres coincide: no hit
        pending_pairs.push_back(make_pair(SHAPE_SPHERE, SHAPE_SPHERE, 0, 0, 0,
                                          ONE, 0, ONE, 0));
        pending_pairs.push_back(make_pair(SHAPE_SPHERE, SHAPE_SPHERE, 5 * ONE, 0, 0,
                                          ONE, 0, ONE, 0));
        // sphere against box, both sides, outside and centre inside
        pending_pairs.push_back(make_pair(SHAPE_SPHERE, SHAPE_BOX, 2 * ONE, ONE, 0,
                                          ONE, 0, 3 * ONE / 2, 3 * ONE / 2));
        pending_pairs.push_back(make_pair(SHAPE_BOX, SHAPE_SPHERE, 0, -2 * ONE, ONE / 2,
                                          3 * ONE / 2, ONE, ONE, 0));
        pending_pairs.push_back(make_pair(SHAPE_SPHERE, SHAPE_BOX, 0, 0, 0,
                                          ONE, 0, 2 * ONE, 2 * ONE));
        pending_pairs.push_back(make_pair(SHAPE_BOX, SHAPE_SPHERE, ONE / 4, -ONE / 3, ONE / 5,
                                          2 * ONE, 3 * ONE, ONE, 0));
        pending_pairs.push_back(make_pair(SHAPE_SPHERE, SHAPE_CAPSULE, ONE, 0, 3 * ONE,
                                          ONE, 0, ONE, 3 * ONE));
        pending_pairs.push_back(make_pair(SHAPE_CAPSULE, SHAPE_SPHERE, 0, 0, 0,
                                          0, 0, 0, 0));
        // box-box: Z dominance, X and Y winners, separation
        pending_pairs.push_back(make_pair(SHAPE_BOX, SHAPE_BOX, ONE, ONE, 2 * ONE,
                                          2 * ONE, 2 * ONE, 2 * ONE, 2 * ONE));
        pending_pairs.push_back(make_pair(SHAPE_BOX, SHAPE_BOX, 3 * ONE, 0, 0,
                                          2 * ONE, 2 * ONE, 2 * ONE, 2 * ONE));
        pending_pairs.push_back(make_pair(SHAPE_BOX, SHAPE_BOX, 0, -3 * ONE, ONE,
                                          2 * ONE, 2 * ONE, 2 * ONE, 2 * ONE));
        pending_pairs.push_back(make_pair(SHAPE_CAPSULE, SHAPE_BOX, 0, 0, 0,
                                          ONE, 4 * ONE, ONE, ONE));
        pending_pairs.push_back(make_pair(SHAPE_BOX, SHAPE_BOX, 9 * ONE, 0, 0,
                                          ONE, ONE, ONE, ONE));
        pending_pairs.push_back(make_pair(SHAPE_ODD, SHAPE_ODD, -ONE, 0, 0,
                                          ONE, ONE, ONE, ONE));
        pending_pairs.push_back(make_pair(SHAPE_ODD, SHAPE_SPHERE, 0, 0, ONE,
                                          ONE, ONE, ONE, 0));
        // extremes: largest sizes and widest offsets
        pending_pairs.push_back(make_pair(SHAPE_BOX, SHAPE_BOX, 0, 0, 0,
                                          30'h3FFF_FFFF, 30'h3FFF_FFFF,
                                          30'h3FFF_FFFF, 30'h3FFF_FFFF));
        pending_pairs.push_back(make_pair(SHAPE_SPHERE, SHAPE_SPHERE, 32'h7FFF_FFFF,
                                          -64'sd2147483648, 32'h7FFF_FFFF,
                                          30'h3FFF_FFFF, 0, 30'h3FFF_FFFF, 0));
        pending_pairs.push_back(make_pair(SHAPE_SPHERE, SHAPE_BOX, -64'sd2147483648,
                                          -64'sd2147483648, -64'sd2147483648,
                                          30'h3FFF_FFFF, 0,
                                          30'h3FFF_FFFF, 30'h3FFF_FFFF));
        random_phase(120);
        drain();

        // extremes of both registers
        write_reg(REG_TINY_DISTANCE_SQ, 32'h0);
        write_reg(REG_VERTICAL_TIE_MARGIN, 32'h0);
        pending_pairs.push_back(make_pair(SHAPE_SPHERE, SHAPE_SPHERE, 0, 0, 1,
                                          ONE, 0, ONE, 0));
        random_phase(110);
        drain();

        write_reg(REG_TINY_DISTANCE_SQ, 32'hFFFF_FFFF);
        write_reg(REG_VERTICAL_TIE_MARGIN, 32'h7FFF_FFFF);
        random_phase(110);
        drain();

        // random settings; sender paused mid-stream until every word is back
        write_reg(REG_TINY_DISTANCE_SQ, $urandom());
        write_reg(REG_VERTICAL_TIE_MARGIN, $urandom_range(0, 4 << 16));
        random_phase(90);
        while (pending_pairs.size() > 45) @(posedge aclk);
        hold_sender = 1'b1;
        while (s_valid || expected_contacts.size() != 0) @(posedge aclk);
        hold_sender = 1'b0;
        drain();

        $display("%0d pairs sent, %0d results checked, %0d contacts, over four settings",
                 pairs_sent, words_checked, hits_seen);
        if (errors == 0 && expected_contacts.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
